/* src/wrfd_pkg.sv */
// Package for the window range flatness detector.
// Holds the fixed field widths and the configuration register codes.
// No dependencies.
package wrfd_pkg;

    // Fixed widths of the payload fields and configuration registers.
    localparam int SAMPLE_W     = 20;
    localparam int START_W      = 32;
    localparam int SPREAD_W     = 20;
    localparam int LEN_W        = 11;
    localparam int LIMIT_W      = 20;
    localparam int CFG_DATA_W   = 20;
    localparam int CFG_INDEX_W  = 1;

    // Configuration register indexes.
    localparam logic [CFG_INDEX_W-1:0] REG_WINDOW_LENGTH = 1'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_SPREAD_LIMIT  = 1'd1;

    // Commands from the controller to the wedge engines.
    typedef struct packed {
        logic start;
        logic clear;
    } wedge_cmd_t;

endpackage

/* src/wrfd_if.sv */
// Valid/ready stream interfaces for samples and results.
// Depends on wrfd_pkg for the field widths.

// Sample stream: one sample per request.
interface wrfd_sample_if;
    logic                          valid;
    logic                          ready;
    logic [wrfd_pkg::SAMPLE_W-1:0] sample;

    modport source (output valid, output sample, input ready);
    modport sink (input valid, input sample, output ready);
endinterface

// Result stream: start index and spread of a flat window.
interface wrfd_result_if;
    logic                          valid;
    logic                          ready;
    logic [wrfd_pkg::START_W-1:0]  window_start;
    logic [wrfd_pkg::SPREAD_W-1:0] spread;

    modport source (output valid, output window_start, output spread, input ready);
    modport sink (input valid, input window_start, input spread, output ready);
endinterface

/* src/wrfd_ram.sv */
// Generic single-clock RAM with one write port and one registered read port.
// No dependencies.
module wrfd_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write port.
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // Registered read port.
    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

/* src/wrfd_wedge.sv */
// One monotonic wedge: a ring of {index, value} entries kept in a RAM,
// with a sequencer that expires the front, pops the back and appends.
// Depends on wrfd_pkg and wrfd_ram.
module wrfd_wedge #(
    parameter bit KEEP_MAX = 1'b1,
    parameter int AW       = 10,
    parameter int VW       = 20
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  wrfd_pkg::wedge_cmd_t cmd,
    input  logic [AW-1:0]        now_lo,
    input  logic [AW-1:0]        expire_lo,
    input  logic [VW-1:0]        value,
    output logic                 idle,
    output logic [VW-1:0]        front
);

    localparam int DW = AW + VW;

    localparam logic [2:0] W_IDLE  = 3'd0;
    localparam logic [2:0] W_EXP   = 3'd1;
    localparam logic [2:0] W_POP   = 3'd2;
    localparam logic [2:0] W_WRITE = 3'd3;
    localparam logic [2:0] W_FRONT = 3'd4;

    logic [2:0]    state_reg, state_next;
    logic [AW-1:0] head_reg, head_next;
    logic [AW:0]   count_reg, count_next;
    logic [AW-1:0] now_reg, now_next;
    logic [AW-1:0] exp_reg, exp_next;
    logic [VW-1:0] val_reg, val_next;
    logic [VW-1:0] front_reg, front_next;

    logic          ram_we;
    logic [AW-1:0] ram_waddr;
    logic [DW-1:0] ram_wdata;
    logic          ram_re;
    logic [AW-1:0] ram_raddr;
    logic [DW-1:0] ram_rdata;

    logic [AW-1:0] rd_idx;
    logic [VW-1:0] rd_val;
    logic          expired;
    logic [AW-1:0] exp_head;
    logic [AW:0]   exp_count;
    logic          pop;

    wrfd_ram #(
        .WIDTH (DW),
        .DEPTH (1 << AW)
    ) u_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    // Fields of the entry read in the previous cycle.
    assign rd_idx = ram_rdata[DW-1:VW];
    assign rd_val = ram_rdata[VW-1:0];

    // The front expires when its index lies exactly one window back.
    assign expired   = (rd_idx == exp_reg);
    assign exp_head  = expired ? head_reg + AW'(1) : head_reg;
    assign exp_count = expired ? count_reg - (AW+1)'(1) : count_reg;

    // A back entry is dominated by the new value.
    assign pop = KEEP_MAX ? (rd_val <= val_reg) : (rd_val >= val_reg);

    // Sequencer: expire, pop back entries, append, fetch the front.
    always_comb
    begin
        state_next = state_reg;
        head_next  = head_reg;
        count_next = count_reg;
        now_next   = now_reg;
        exp_next   = exp_reg;
        val_next   = val_reg;
        front_next = front_reg;
        ram_we     = 1'b0;
        ram_waddr  = head_reg + count_reg[AW-1:0];
        ram_wdata  = {now_reg, val_reg};
        ram_re     = 1'b0;
        ram_raddr  = head_reg;

        unique case (state_reg)
            W_IDLE:
            begin
                priority if (cmd.clear)
                begin
                    head_next  = '0;
                    count_next = '0;
                end
                else if (cmd.start)
                begin
                    now_next = now_lo;
                    exp_next = expire_lo;
                    val_next = value;
                    if (count_reg != '0)
                    begin
                        ram_re     = 1'b1;
                        ram_raddr  = head_reg;
                        state_next = W_EXP;
                    end
                    else
                    begin
                        state_next = W_WRITE;
                    end
                end
                else
                begin
                end
            end
            W_EXP:
            begin
                head_next  = exp_head;
                count_next = exp_count;
                if (exp_count == '0)
                begin
                    state_next = W_WRITE;
                end
                else
                begin
                    ram_re     = 1'b1;
                    ram_raddr  = exp_head + exp_count[AW-1:0] - AW'(1);
                    state_next = W_POP;
                end
            end
            W_POP:
            begin
                if (pop)
                begin
                    count_next = count_reg - (AW+1)'(1);
                    if (count_reg == (AW+1)'(1))
                    begin
                        state_next = W_WRITE;
                    end
                    else
                    begin
                        ram_re    = 1'b1;
                        ram_raddr = head_reg + count_reg[AW-1:0] - AW'(2);
                    end
                end
                else
                begin
                    state_next = W_WRITE;
                end
            end
            W_WRITE:
            begin
                ram_we     = 1'b1;
                count_next = count_reg + (AW+1)'(1);
                if (count_reg == '0)
                begin
                    // The new entry is the front; forward it.
                    front_next = val_reg;
                end
                else
                begin
                    ram_re    = 1'b1;
                    ram_raddr = head_reg;
                end
                state_next = W_FRONT;
            end
            W_FRONT:
            begin
                if (count_reg != (AW+1)'(1))
                begin
                    front_next = rd_val;
                end
                state_next = W_IDLE;
            end
            default:
            begin
                state_next = W_IDLE;
            end
        endcase
    end

    // Control state.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= W_IDLE;
            head_reg  <= '0;
            count_reg <= '0;
        end
        else
        begin
            state_reg <= state_next;
            head_reg  <= head_next;
            count_reg <= count_next;
        end
    end

    // Working registers of the current request.
    always_ff @(posedge clk)
    begin
        now_reg   <= now_next;
        exp_reg   <= exp_next;
        val_reg   <= val_next;
        front_reg <= front_next;
    end

    assign idle  = (state_reg == W_IDLE);
    assign front = front_reg;

endmodule

/* src/window_range_flatness_detect_top.sv */
// Window range flatness detector: running max and min over a sliding window.
// Each request runs both wedges through expire, pop, append and front fetch, then the
// window check registers a result if the window is flat. One request at a time: a new
// one is taken once the last is checked, and a flat result waits for a full output.
// Reset empties both wedges at once through their entry counts; no clearing pass.
// Depends on wrfd_pkg, wrfd_if and wrfd_wedge.
module window_range_flatness_detect_top #(
    parameter int MAX_WINDOW  = 1024,
    parameter int SAMPLE_BITS = 20
) (
    input  logic                             clk,
    input  logic                             rst_n,
    wrfd_sample_if.sink                      samples,
    wrfd_result_if.source                    results,
    input  logic                             cfg_wr_en,
    input  logic [wrfd_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  logic [wrfd_pkg::CFG_DATA_W-1:0]  cfg_data
);

    localparam int AW = $clog2(MAX_WINDOW);
    localparam int LW = $clog2(MAX_WINDOW + 1);
    localparam int VW = (SAMPLE_BITS < wrfd_pkg::SAMPLE_W) ? SAMPLE_BITS : wrfd_pkg::SAMPLE_W;

    localparam logic T_IDLE = 1'b0;
    localparam logic T_WAIT = 1'b1;

    logic                              state_reg, state_next;
    logic [wrfd_pkg::LEN_W-1:0]        window_length_reg;
    logic [wrfd_pkg::LIMIT_W-1:0]      spread_limit_reg;
    logic [wrfd_pkg::START_W-1:0]      sample_index_reg;
    logic [wrfd_pkg::START_W-1:0]      now_reg;
    logic [LW-1:0]                     fill_reg;
    logic                              out_valid_reg, out_valid_next;
    logic [wrfd_pkg::START_W-1:0]      out_start_reg;
    logic [wrfd_pkg::SPREAD_W-1:0]     out_spread_reg;

    logic [LW-1:0]                     len;
    logic                              accept;
    logic                              len_write;
    wrfd_pkg::wedge_cmd_t              cmd;
    logic                              max_idle, min_idle;
    logic [VW-1:0]                     max_front, min_front;
    logic [VW-1:0]                     spread;
    logic                              qualify;
    logic                              engines_done;
    logic                              out_free;
    logic                              load_out;

    // Effective window length: zero acts as one, oversized values clamp.
    always_comb
    begin
        priority if (window_length_reg == '0)
        begin
            len = LW'(1);
        end
        else if (32'(window_length_reg) > MAX_WINDOW)
        begin
            len = LW'(MAX_WINDOW);
        end
        else
        begin
            len = LW'(window_length_reg);
        end
    end

    // Request handshake and wedge commands.
    assign samples.ready = (state_reg == T_IDLE);
    assign accept        = samples.valid && samples.ready;
    assign len_write     = cfg_wr_en && (cfg_index == wrfd_pkg::REG_WINDOW_LENGTH);
    assign cmd           = '{start: accept, clear: len_write};

    wrfd_wedge #(
        .KEEP_MAX (1'b1),
        .AW       (AW),
        .VW       (VW)
    ) u_max_wedge (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .now_lo    (AW'(sample_index_reg)),
        .expire_lo (AW'(sample_index_reg) - AW'(len)),
        .value     (samples.sample[VW-1:0]),
        .idle      (max_idle),
        .front     (max_front)
    );

    wrfd_wedge #(
        .KEEP_MAX (1'b0),
        .AW       (AW),
        .VW       (VW)
    ) u_min_wedge (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .now_lo    (AW'(sample_index_reg)),
        .expire_lo (AW'(sample_index_reg) - AW'(len)),
        .value     (samples.sample[VW-1:0]),
        .idle      (min_idle),
        .front     (min_front)
    );

    // Window check once both wedges have settled.
    assign engines_done = max_idle && min_idle;
    assign spread       = max_front - min_front;
    assign qualify      = (fill_reg >= len)
                          && (wrfd_pkg::SPREAD_W'(spread) <= spread_limit_reg);
    assign out_free     = !out_valid_reg || results.ready;
    assign load_out     = (state_reg == T_WAIT) && engines_done && qualify && out_free;

    // Controller state.
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            T_IDLE:
            begin
                if (accept)
                begin
                    state_next = T_WAIT;
                end
            end
            T_WAIT:
            begin
                if (engines_done && (!qualify || out_free))
                begin
                    state_next = T_IDLE;
                end
            end
            default:
            begin
                state_next = T_IDLE;
            end
        endcase
    end

    // Output register valid.
    always_comb
    begin
        priority if (load_out)
        begin
            out_valid_next = 1'b1;
        end
        else if (results.ready)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    // Control state, counters and configuration registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg         <= T_IDLE;
            out_valid_reg     <= 1'b0;
            sample_index_reg  <= '0;
            fill_reg          <= '0;
            window_length_reg <= wrfd_pkg::LEN_W'(1);
            spread_limit_reg  <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
            if (accept)
            begin
                sample_index_reg <= sample_index_reg + wrfd_pkg::START_W'(1);
                if (fill_reg < LW'(MAX_WINDOW))
                begin
                    fill_reg <= fill_reg + LW'(1);
                end
            end
            if (cfg_wr_en)
            begin
                unique case (cfg_index)
                    wrfd_pkg::REG_WINDOW_LENGTH:
                    begin
                        window_length_reg <= cfg_data[wrfd_pkg::LEN_W-1:0];
                        fill_reg          <= '0;
                    end
                    wrfd_pkg::REG_SPREAD_LIMIT:
                    begin
                        spread_limit_reg <= cfg_data[wrfd_pkg::LIMIT_W-1:0];
                    end
                    default:
                    begin
                    end
                endcase
            end
        end
    end

    // Payload registers.
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            now_reg <= sample_index_reg;
        end
        if (load_out)
        begin
            out_start_reg  <= now_reg - wrfd_pkg::START_W'(len) + wrfd_pkg::START_W'(1);
            out_spread_reg <= wrfd_pkg::SPREAD_W'(spread);
        end
    end

    assign results.valid        = out_valid_reg;
    assign results.window_start = out_start_reg;
    assign results.spread       = out_spread_reg;

`ifndef ASSERT_OFF
    // A request starts only when both wedge engines are free.
    a_start_idle: assert property (@(posedge clk) disable iff (!rst_n)
        accept |-> (max_idle && min_idle))
        else $error("request accepted while a wedge engine is busy");

    // While the controller idles, neither engine may be working.
    a_idle_agree: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == T_IDLE) |-> (max_idle && min_idle))
        else $error("wedge engine busy while controller idles");

    // A new result is loaded only at the end of a request.
    a_result_origin: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(state_reg == T_WAIT && engines_done))
        else $error("result appeared outside the end of a request");
`endif

endmodule
